// ===== rtl/core/nts_pkg.sv =====
// Shared types, codes and constants for the note table step sequencer.
package nts_pkg;

    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;
    localparam int SPT_W  = 24;
    localparam int MPT_W  = 14;
    localparam int LEN_W  = 9;
    localparam int DUR_W  = 22;
    localparam int WAIT_W = 8;

    localparam logic [SPT_W-1:0] SPT_RESET = 24'd5000;
    localparam logic [MPT_W-1:0] MPT_RESET = 14'd125;
    localparam logic [LEN_W-1:0] LEN_RESET = 9'd0;

    // register indexes (word address bits)
    localparam logic [1:0] REG_SPT = 2'd0;
    localparam logic [1:0] REG_MPT = 2'd1;
    localparam logic [1:0] REG_LEN = 2'd2;

    // input kinds
    localparam logic [1:0] KIND_TICK  = 2'd0;
    localparam logic [1:0] KIND_WRITE = 2'd1;
    localparam logic [1:0] KIND_START = 2'd2;
    localparam logic [1:0] KIND_STOP  = 2'd3;

    // result events
    localparam logic EV_PLAY = 1'b0;
    localparam logic EV_STOP = 1'b1;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] entry_index;
        logic [7:0] note_pitch;
        logic [7:0] note_preset;
        logic [7:0] note_length;
        logic [7:0] note_advance;
    } nts_in_t;

    typedef struct packed {
        logic             event_res;
        logic [7:0]       pitch;
        logic [7:0]       preset;
        logic [DUR_W-1:0] duration_ms;
        logic             last;
    } nts_out_t;

    typedef struct packed {
        logic [7:0] advance;
        logic [7:0] length;
        logic [7:0] preset;
        logic [7:0] pitch;
    } nts_entry_t;

    typedef struct packed {
        logic [SPT_W-1:0] samples_per_tick;
        logic [MPT_W-1:0] ms_per_tick;
        logic [LEN_W-1:0] melody_length;
    } nts_cfg_t;

    typedef struct packed {
        logic write_entry;
        logic start;
        logic stop;
        logic count;
        logic tick;
        logic halt;
        logic cap;
        logic read;
        logic load;
        logic push;
        logic flush;
    } nts_cmd_t;

    typedef struct packed {
        logic [1:0] kind;
        logic       running;
        logic       tick_due;
        logic       wait_zero;
        logic       pos_end;
        logic       cap_hit;
        logic       pitch_nz;
        logic       pend_valid;
        logic       out_free;
    } nts_status_t;

endpackage

// ===== rtl/core/nts_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module nts_ram
    import nts_pkg::*;
#(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/nts_ctrl.sv =====
// Sequencer control state machine: input acceptance, table walk and result flush.
module nts_ctrl
    import nts_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  nts_status_t status,
    output nts_cmd_t    cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_WALK  = 3'd1;
    localparam logic [2:0] S_ENTRY = 3'd2;
    localparam logic [2:0] S_NOTE  = 3'd3;
    localparam logic [2:0] S_FLUSH = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (status.kind)
                        KIND_TICK:
                        begin
                            if (status.running)
                            begin
                                if (status.tick_due)
                                begin
                                    cmd.tick   = 1'b1;
                                    state_next = S_WALK;
                                end
                                else
                                begin
                                    cmd.count = 1'b1;
                                end
                            end
                        end
                        KIND_WRITE:
                        begin
                            cmd.write_entry = 1'b1;
                        end
                        KIND_START:
                        begin
                            cmd.start = 1'b1;
                        end
                        KIND_STOP:
                        begin
                            cmd.stop   = 1'b1;
                            state_next = S_FLUSH;
                        end
                    endcase
                end
            end
            S_WALK:
            begin
                priority if (!status.running || !status.wait_zero)
                begin
                    state_next = S_FLUSH;
                end
                else if (status.pos_end)
                begin
                    cmd.halt   = 1'b1;
                    state_next = S_FLUSH;
                end
                else if (status.cap_hit)
                begin
                    // pause; the next sample tick resumes the walk
                    cmd.cap    = 1'b1;
                    state_next = S_FLUSH;
                end
                else
                begin
                    cmd.read   = 1'b1;
                    state_next = S_ENTRY;
                end
            end
            S_ENTRY:
            begin
                cmd.load   = 1'b1;
                state_next = status.pitch_nz ? S_NOTE : S_WALK;
            end
            S_NOTE:
            begin
                // hold until the older pending result can move to the output
                if (!status.pend_valid || status.out_free)
                begin
                    cmd.push   = 1'b1;
                    state_next = S_WALK;
                end
            end
            S_FLUSH:
            begin
                if (!status.pend_valid || status.out_free)
                begin
                    cmd.flush  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== rtl/core/nts_datapath.sv =====
// Sequencer datapath: note table, playback counters, pending and output result registers.
module nts_datapath
    import nts_pkg::*;
#(
    parameter int TABLE_DEPTH        = 256,
    parameter int MAX_NOTES_PER_TICK = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  nts_in_t     in_data,
    input  nts_cfg_t    cfg,
    input  nts_cmd_t    cmd,
    output nts_status_t status,
    output logic        out_valid,
    input  logic        out_stall,
    output nts_out_t    out_data
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int NW = $clog2(MAX_NOTES_PER_TICK + 1);

    // entry_index reduced modulo the table depth
    logic [AW-1:0] widx_lut [256];
    for (genvar g = 0; g < 256; g++)
    begin : g_widx
        assign widx_lut[g] = AW'(g % TABLE_DEPTH);
    end

    logic             running_reg, running_next;
    logic [LEN_W-1:0] pos_reg, pos_next;
    logic [AW-1:0]    idx_reg, idx_next;
    logic [SPT_W-1:0] sc_reg, sc_next;
    logic [WAIT_W-1:0] wait_reg, wait_next;
    logic [NW-1:0]    n_reg, n_next;
    logic             out_valid_reg, out_valid_next;
    logic             pend_valid_reg, pend_valid_next;
    nts_out_t         out_data_reg, out_data_next;
    nts_out_t         pend_reg, pend_next;
    logic [DUR_W-1:0] prod_reg, prod_next;
    logic [7:0]       ent_pitch_reg, ent_pitch_next;
    logic [7:0]       ent_preset_reg, ent_preset_next;

    logic [SPT_W:0]   count_inc;
    logic             out_free;
    nts_entry_t       wentry;
    nts_entry_t       rentry;
    logic [31:0]      rdata;

    assign wentry.advance = in_data.note_advance;
    assign wentry.length  = in_data.note_length;
    assign wentry.preset  = in_data.note_preset;
    assign wentry.pitch   = in_data.note_pitch;
    assign rentry         = nts_entry_t'(rdata);

    nts_ram #(
        .WIDTH (32),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (cmd.write_entry),
        .waddr (widx_lut[in_data.entry_index]),
        .wdata (wentry),
        .re    (cmd.read),
        .raddr (idx_reg),
        .rdata (rdata)
    );

    assign count_inc = {1'b0, sc_reg} + 1'b1;
    assign out_free  = !out_valid_reg || !out_stall;

    assign status.kind       = in_data.kind;
    assign status.running    = running_reg;
    assign status.tick_due   = count_inc >= {1'b0, cfg.samples_per_tick};
    assign status.wait_zero  = (wait_reg == '0);
    assign status.pos_end    = (pos_reg >= cfg.melody_length);
    assign status.cap_hit    = (n_reg >= NW'(MAX_NOTES_PER_TICK));
    assign status.pitch_nz   = (rentry.pitch != '0);
    assign status.pend_valid = pend_valid_reg;
    assign status.out_free   = out_free;

    always_comb
    begin
        running_next    = running_reg;
        pos_next        = pos_reg;
        idx_next        = idx_reg;
        sc_next         = sc_reg;
        wait_next       = wait_reg;
        n_next          = n_reg;
        out_valid_next  = out_valid_reg;
        pend_valid_next = pend_valid_reg;
        out_data_next   = out_data_reg;
        pend_next       = pend_reg;
        prod_next       = prod_reg;
        ent_pitch_next  = ent_pitch_reg;
        ent_preset_next = ent_preset_reg;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        if (cmd.start)
        begin
            pos_next     = '0;
            idx_next     = '0;
            sc_next      = cfg.samples_per_tick;
            wait_next    = '0;
            running_next = (cfg.melody_length != '0);
        end

        if (cmd.stop)
        begin
            running_next          = 1'b0;
            pend_next.event_res   = EV_STOP;
            pend_next.pitch       = '0;
            pend_next.preset      = '0;
            pend_next.duration_ms = '0;
            pend_next.last        = 1'b0;
            pend_valid_next       = 1'b1;
        end

        if (cmd.count)
        begin
            sc_next = count_inc[SPT_W-1:0];
        end

        if (cmd.tick)
        begin
            sc_next = '0;
            n_next  = '0;
            if (wait_reg != '0)
            begin
                wait_next = wait_reg - 1'b1;
            end
        end

        if (cmd.halt)
        begin
            running_next = 1'b0;
        end

        if (cmd.cap)
        begin
            sc_next = cfg.samples_per_tick;
        end

        if (cmd.load)
        begin
            prod_next       = DUR_W'(rentry.length) * DUR_W'(cfg.ms_per_tick);
            ent_pitch_next  = rentry.pitch;
            ent_preset_next = rentry.preset;
            wait_next       = rentry.advance;
            pos_next        = pos_reg + 1'b1;
            idx_next        = (idx_reg == AW'(TABLE_DEPTH - 1)) ? '0 : idx_reg + 1'b1;
        end

        if (cmd.push)
        begin
            // the older pending note is known not to be the last one now
            if (pend_valid_reg)
            begin
                out_data_next      = pend_reg;
                out_data_next.last = 1'b0;
                out_valid_next     = 1'b1;
            end
            pend_next.event_res   = EV_PLAY;
            pend_next.pitch       = ent_pitch_reg;
            pend_next.preset      = ent_preset_reg;
            pend_next.duration_ms = prod_reg;
            pend_next.last        = 1'b0;
            pend_valid_next       = 1'b1;
            n_next                = n_reg + 1'b1;
        end

        if (cmd.flush && pend_valid_reg)
        begin
            out_data_next      = pend_reg;
            out_data_next.last = 1'b1;
            out_valid_next     = 1'b1;
            pend_valid_next    = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg    <= 1'b0;
            pos_reg        <= '0;
            idx_reg        <= '0;
            sc_reg         <= '0;
            wait_reg       <= '0;
            n_reg          <= '0;
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            running_reg    <= running_next;
            pos_reg        <= pos_next;
            idx_reg        <= idx_next;
            sc_reg         <= sc_next;
            wait_reg       <= wait_next;
            n_reg          <= n_next;
            out_valid_reg  <= out_valid_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg   <= out_data_next;
        pend_reg       <= pend_next;
        prod_reg       <= prod_next;
        ent_pitch_reg  <= ent_pitch_next;
        ent_preset_reg <= ent_preset_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ===== rtl/core/note_table_step_sequencer_core.sv =====
// Writes, starts and sample ticks that end no sixteenth are taken in S_IDLE.
// A stop moves through S_FLUSH; its result is pended, then registered at the output.
// A tick that ends a sixteenth walks the table, S_WALK then S_ENTRY per entry (table read,
// duration multiply), with S_NOTE per sounding entry (result hand-off); it ends in S_FLUSH.
// Results leave through an output register; a stalled output holds the walk.
// Reset clears control state and config registers to defaults; table entries are undefined.
module note_table_step_sequencer_core
    import nts_pkg::*;
#(
    parameter int TABLE_DEPTH        = 256,
    parameter int MAX_NOTES_PER_TICK = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    input  logic              in_valid,
    output logic              in_stall,
    input  nts_in_t           in_data,
    output logic              out_valid,
    input  logic              out_stall,
    output nts_out_t          out_data
);

    logic [SPT_W-1:0] spt_reg;
    logic [MPT_W-1:0] mpt_reg;
    logic [LEN_W-1:0] len_reg;
    logic             wr_en;
    nts_cfg_t         cfg;
    nts_cmd_t         cmd;
    nts_status_t      status;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spt_reg <= SPT_RESET;
            mpt_reg <= MPT_RESET;
            len_reg <= LEN_RESET;
        end
        else if (wr_en)
        begin
            unique case (paddr[3:2])
                REG_SPT: spt_reg <= pwdata[SPT_W-1:0];
                REG_MPT: mpt_reg <= pwdata[MPT_W-1:0];
                REG_LEN: len_reg <= pwdata[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_SPT: prdata = DATA_W'(spt_reg);
            REG_MPT: prdata = DATA_W'(mpt_reg);
            REG_LEN: prdata = DATA_W'(len_reg);
            default: prdata = '0;
        endcase
    end

    assign cfg.samples_per_tick = spt_reg;
    assign cfg.ms_per_tick      = mpt_reg;
    assign cfg.melody_length    = len_reg;

    nts_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    nts_datapath #(
        .TABLE_DEPTH        (TABLE_DEPTH),
        .MAX_NOTES_PER_TICK (MAX_NOTES_PER_TICK)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cfg       (cfg),
        .cmd       (cmd),
        .status    (status),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    // nothing may be left pending once a new transaction can be taken
    a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
        !in_stall |-> !status.pend_valid)
        else $error("pending result while accepting input");

    a_stop_pends: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && in_data.kind == KIND_STOP) |=> status.pend_valid)
        else $error("stop transaction left no result");

    a_stop_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.event_res == EV_STOP) |-> out_data.last)
        else $error("stop result not marked last");

    a_play_pitch: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.event_res == EV_PLAY) |-> (out_data.pitch != '0))
        else $error("play result for a rest");

endmodule
